// ----- sv/alre_pkg.sv -----
// shared types and constants of the antialiased line raster engine
package alre_pkg;

	localparam int COORD_BITS = 16;
	localparam int CHAN_BITS  = 8;
	localparam int REG_BITS   = 7;
	localparam int FRAC_SHIFT = 16;

	typedef enum logic [1:0] {
		KIND_READ = 2'd0,
		KIND_LINE = 2'd1,
		KIND_FILL = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_RESULT,
		ST_FILL,
		ST_LN_SETUP,
		ST_LN_END1,
		ST_LN_END2,
		ST_LN_CLASS,
		ST_LN_PLAIN,
		ST_LN_DIV,
		ST_LN_STEP,
		ST_LN_BL_RD,
		ST_LN_BL_WAIT,
		ST_LN_BL_WR
	} state_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} pixel_t;

	// per-channel blend with weight w in 0..255
	function automatic logic [CHAN_BITS-1:0] blend_chan(
		input logic [CHAN_BITS-1:0] d,
		input logic [CHAN_BITS-1:0] s,
		input logic [CHAN_BITS:0]   w
	);
		logic [2*CHAN_BITS:0] a;
		logic [2*CHAN_BITS:0] b;
		logic [CHAN_BITS:0]   inv;
		logic [CHAN_BITS:0]   sum;
		inv = 9'd256 - w;
		a = {1'b0, d} * inv;
		b = {1'b0, s} * w;
		sum = {1'b0, a[2*CHAN_BITS-1:CHAN_BITS]} + {1'b0, b[2*CHAN_BITS-1:CHAN_BITS]};
		return sum[CHAN_BITS-1:0];
	endfunction

endpackage

// ----- sv/alre_if.sv -----
// valid/ready channel interfaces of the raster engine
interface alre_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] x_start;
	logic [15:0] y_start;
	logic [15:0] x_end;
	logic [15:0] y_end;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	modport source (output valid, kind, x_start, y_start, x_end, y_end, red, green, blue,
		alpha, input ready);
	modport sink (input valid, kind, x_start, y_start, x_end, y_end, red, green, blue,
		alpha, output ready);
endinterface

interface alre_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_alpha;
	logic       out_of_range;
	modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
		out_of_range, input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
		out_of_range, output ready);
endinterface

interface alre_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/antialiased_line_raster_engine.sv -----
// antialiased line raster engine top level
// Commands run one at a time against a MAX_WIDTH x MAX_HEIGHT RGBA store in a memory with
// one write port and one registered read port. After reset a clearing pass zeroes the
// whole store before the first request is taken. A read passes through an address and a
// data state before it answers; a fill writes every pixel of the image in use. A line
// first clamps its end points, writes them and classifies itself, and sloped lines then
// run the shift-subtract slope divider; plain lines then write their pixels directly, and
// antialiased ones do two read-modify-write blends per major-axis step. Every command
// returns one response.
module antialiased_line_raster_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int PIXEL_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	alre_cmd_if.sink   cmd,
	alre_rsp_if.source rsp,
	alre_cfg_if.sink   cfg
);
	localparam int XW    = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
	localparam int CW    = alre_pkg::COORD_BITS;
	localparam int SW    = CW + 2;

	alre_pkg::state_t state_q, state_d;

	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic [PIXEL_BITS-1:0] rdata_q;
	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [PIXEL_BITS-1:0] wdata;

	logic [alre_pkg::REG_BITS-1:0] width_reg_q, height_reg_q;
	logic signed [SW-1:0] eff_w, eff_h;

	logic [PIXEL_BITS-1:0] colour_q;
	logic signed [SW-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic signed [SW-1:0]  px_q, py_q;
	logic signed [SW-1:0]  dx_q, dy_q;
	logic                  neg_q;
	logic [AW:0]           cnt_q;
	logic [15:0]           k_q, len_q;
	logic [31:0]           acc_q, adj_q;
	logic [47:0]           rem_q;
	logic [5:0]            div_cnt_q;
	logic                  second_q;
	logic [7:0]            frac_q;
	logic [7:0]            pr_q, pg_q, pb_q, pa_q;
	logic                  oor_q;

	// image in use, clamped to the store
	always_comb begin
		eff_w = SW'(width_reg_q);
		if (width_reg_q == '0) eff_w = SW'(1);
		if (eff_w > SW'(MAX_WIDTH)) eff_w = SW'(MAX_WIDTH);
		eff_h = SW'(height_reg_q);
		if (height_reg_q == '0) eff_h = SW'(1);
		if (eff_h > SW'(MAX_HEIGHT)) eff_h = SW'(MAX_HEIGHT);
	end

	function automatic logic signed [SW-1:0] clampc(input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] hi);
		if (v < 0) return '0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic signed [SW-1:0] x,
		input logic signed [SW-1:0] y);
		logic [AW-1:0] a;
		a = AW'(y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x[XW-1:0]);
		return a;
	endfunction

	function automatic logic is_in(input logic signed [SW-1:0] x,
		input logic signed [SW-1:0] y, input logic signed [SW-1:0] w,
		input logic signed [SW-1:0] h);
		return x >= 0 && y >= 0 && x < w && y < h;
	endfunction

	// current blend target
	logic signed [SW-1:0] bx, by;
	logic                 b_in;
	logic [8:0]           b_w;
	always_comb begin
		bx = px_q;
		by = py_q;
		if (second_q) begin
			if (dy_q > dx_q) bx = neg_q ? px_q - SW'(1) : px_q + SW'(1);
			else by = py_q + SW'(1);
		end
		b_in = is_in(bx, by, eff_w, eff_h);
		b_w  = second_q ? {1'b0, frac_q} : 9'd255 - {1'b0, frac_q};
	end

	alre_pkg::pixel_t old_px, col_px, new_px;
	always_comb begin
		old_px = rdata_q;
		col_px = {colour_q[7:0], colour_q[15:8], colour_q[23:16], colour_q[31:24]};
		old_px = {rdata_q[7:0], rdata_q[15:8], rdata_q[23:16], rdata_q[31:24]};
		new_px.red   = alre_pkg::blend_chan(old_px.red, col_px.red, b_w);
		new_px.green = alre_pkg::blend_chan(old_px.green, col_px.green, b_w);
		new_px.blue  = alre_pkg::blend_chan(old_px.blue, col_px.blue, b_w);
		new_px.alpha = alre_pkg::blend_chan(old_px.alpha, col_px.alpha, b_w);
	end

	// plain-line pixel for step k
	logic signed [SW-1:0] plx, ply;
	always_comb begin
		plx = x1_q;
		ply = y1_q;
		if (dx_q == 0) ply = y1_q + SW'(k_q);
		else if (dy_q == 0) plx = (x1_q < x2_q ? x1_q : x2_q) + SW'(k_q);
		else begin
			plx = neg_q ? x1_q - SW'(k_q) : x1_q + SW'(k_q);
			ply = y1_q + SW'(k_q);
		end
	end

	logic [31:0] acc_n;
	assign acc_n = acc_q + adj_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			alre_pkg::ST_CLEAR: if (cnt_q == (AW+1)'(DEPTH - 1)) state_d = alre_pkg::ST_IDLE;
			alre_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					case (alre_pkg::kind_t'(cmd.kind))
						alre_pkg::KIND_READ: state_d = alre_pkg::ST_RD_ADDR;
						alre_pkg::KIND_LINE: state_d = alre_pkg::ST_LN_SETUP;
						alre_pkg::KIND_FILL: state_d = alre_pkg::ST_FILL;
						default:             state_d = alre_pkg::ST_RESULT;
					endcase
				end
			end
			alre_pkg::ST_RD_ADDR: state_d = alre_pkg::ST_RD_DATA;
			alre_pkg::ST_RD_DATA: state_d = alre_pkg::ST_RESULT;
			alre_pkg::ST_RESULT: if (rsp.ready) state_d = alre_pkg::ST_IDLE;
			alre_pkg::ST_FILL:
				if (px_q == eff_w - 1 && py_q == eff_h - 1) state_d = alre_pkg::ST_RESULT;
			alre_pkg::ST_LN_SETUP: state_d = alre_pkg::ST_LN_END1;
			alre_pkg::ST_LN_END1:  state_d = alre_pkg::ST_LN_END2;
			alre_pkg::ST_LN_END2:  state_d = alre_pkg::ST_LN_CLASS;
			alre_pkg::ST_LN_CLASS: begin
				if (dx_q == 0 || dy_q == 0 || dx_q == dy_q)
					state_d = (dx_q == 0 && dy_q == 0) ? alre_pkg::ST_RESULT
						: alre_pkg::ST_LN_PLAIN;
				else state_d = alre_pkg::ST_LN_DIV;
			end
			alre_pkg::ST_LN_PLAIN: if (k_q == len_q - 16'd1) state_d = alre_pkg::ST_RESULT;
			alre_pkg::ST_LN_DIV: if (div_cnt_q == 6'd32) state_d = alre_pkg::ST_LN_STEP;
			alre_pkg::ST_LN_STEP: state_d = alre_pkg::ST_LN_BL_RD;
			alre_pkg::ST_LN_BL_RD: state_d = b_in ? alre_pkg::ST_LN_BL_WAIT
				: alre_pkg::ST_LN_BL_WR;
			alre_pkg::ST_LN_BL_WAIT: state_d = alre_pkg::ST_LN_BL_WR;
			alre_pkg::ST_LN_BL_WR: begin
				if (!second_q) state_d = alre_pkg::ST_LN_BL_RD;
				else if (k_q == len_q - 16'd1) state_d = alre_pkg::ST_RESULT;
				else state_d = alre_pkg::ST_LN_STEP;
			end
			default: state_d = alre_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory port
	always_comb begin
		cmd.ready = state_q == alre_pkg::ST_IDLE;
		rsp.valid = state_q == alre_pkg::ST_RESULT;
		cfg.ready = 1'b1;
		we    = 1'b0;
		waddr = addr_of(px_q, py_q);
		wdata = colour_q;
		raddr = addr_of(px_q, py_q);
		case (state_q)
			alre_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = '0;
			end
			alre_pkg::ST_FILL: we = 1'b1;
			alre_pkg::ST_LN_END1: begin
				we    = 1'b1;
				waddr = addr_of(x1_q, y1_q);
			end
			alre_pkg::ST_LN_END2: begin
				we    = 1'b1;
				waddr = addr_of(x2_q, y2_q);
			end
			alre_pkg::ST_LN_PLAIN: begin
				we    = is_in(plx, ply, eff_w, eff_h);
				waddr = addr_of(plx, ply);
			end
			alre_pkg::ST_LN_BL_RD: raddr = addr_of(bx, by);
			alre_pkg::ST_LN_BL_WAIT: raddr = addr_of(bx, by);
			alre_pkg::ST_LN_BL_WR: begin
				we    = b_in;
				waddr = addr_of(bx, by);
				wdata = {new_px.alpha, new_px.blue, new_px.green, new_px.red};
			end
			default: ;
		endcase
		rsp.pixel_red    = pr_q;
		rsp.pixel_green  = pg_q;
		rsp.pixel_blue   = pb_q;
		rsp.pixel_alpha  = pa_q;
		rsp.out_of_range = oor_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= alre_pkg::ST_CLEAR;
			cnt_q        <= '0;
			width_reg_q  <= 7'd64;
			height_reg_q <= 7'd64;
		end else begin
			state_q <= state_d;
			if (state_q == alre_pkg::ST_CLEAR) cnt_q <= cnt_q + (AW+1)'(1);
			if (cfg.valid) begin
				case (alre_pkg::reg_idx_t'(cfg.index))
					alre_pkg::REG_WIDTH:  width_reg_q <= cfg.data;
					alre_pkg::REG_HEIGHT: height_reg_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	logic signed [SW-1:0] xs_in, ys_in, xe_in, ye_in;
	assign xs_in = SW'($signed(cmd.x_start));
	assign ys_in = SW'($signed(cmd.y_start));
	assign xe_in = SW'($signed(cmd.x_end));
	assign ye_in = SW'($signed(cmd.y_end));

	logic [47:0] rem_sh;
	assign rem_sh = {rem_q[46:0], 1'b0};

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			alre_pkg::ST_IDLE: begin
				colour_q <= {cmd.alpha, cmd.blue, cmd.green, cmd.red};
				// a read addresses the store straight from its start point
				px_q     <= cmd.kind == alre_pkg::KIND_READ ? xs_in : '0;
				py_q     <= cmd.kind == alre_pkg::KIND_READ ? ys_in : '0;
				pr_q <= '0; pg_q <= '0; pb_q <= '0; pa_q <= '0; oor_q <= 1'b0;
				if (ys_in > ye_in) begin
					x1_q <= xe_in; y1_q <= ye_in; x2_q <= xs_in; y2_q <= ys_in;
				end else begin
					x1_q <= xs_in; y1_q <= ys_in; x2_q <= xe_in; y2_q <= ye_in;
				end
			end
			alre_pkg::ST_RD_DATA: begin
				if (is_in(px_q, py_q, eff_w, eff_h)) begin
					pr_q <= rdata_q[7:0];
					pg_q <= rdata_q[15:8];
					pb_q <= rdata_q[23:16];
					pa_q <= rdata_q[31:24];
				end else oor_q <= 1'b1;
			end
			alre_pkg::ST_FILL: begin
				if (px_q == eff_w - 1) begin
					px_q <= '0;
					py_q <= py_q + SW'(1);
				end else px_q <= px_q + SW'(1);
			end
			alre_pkg::ST_LN_SETUP: begin
				x1_q <= clampc(x1_q, eff_w - 1);
				x2_q <= clampc(x2_q, eff_w - 1);
				y1_q <= clampc(y1_q, eff_h - 1);
				y2_q <= clampc(y2_q, eff_h - 1);
			end
			alre_pkg::ST_LN_END2: begin
				neg_q <= x2_q < x1_q;
				dx_q  <= x2_q < x1_q ? x1_q - x2_q : x2_q - x1_q;
				dy_q  <= y2_q - y1_q;
				k_q   <= '0;
			end
			alre_pkg::ST_LN_CLASS: begin
				// steps along the major axis, dx when horizontal
				len_q     <= dy_q > dx_q ? 16'(dy_q) : 16'(dx_q);
				rem_q     <= dy_q > dx_q ? 48'(dx_q) << 16 : 48'(dy_q) << 16;
				adj_q     <= '0;
				acc_q     <= '0;
				div_cnt_q <= '0;
				px_q      <= x1_q;
				py_q      <= y1_q;
			end
			alre_pkg::ST_LN_PLAIN: k_q <= k_q + 16'd1;
			alre_pkg::ST_LN_DIV: begin
				// restoring division, one quotient bit per cycle
				if (div_cnt_q != 6'd32) begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (rem_sh[47:32] >= 16'(len_q)) begin
						rem_q <= {rem_sh[47:32] - len_q, rem_sh[31:1], 1'b1};
					end else rem_q <= rem_sh;
				end else begin
					adj_q <= rem_q[31:0];
					k_q   <= '0;
				end
			end
			alre_pkg::ST_LN_STEP: begin
				acc_q    <= acc_n;
				frac_q   <= acc_n[15:8];
				second_q <= 1'b0;
				if (dy_q > dx_q) begin
					py_q <= y1_q + SW'(k_q) + SW'(1);
					px_q <= neg_q ? x1_q - SW'(acc_n[31:16]) : x1_q + SW'(acc_n[31:16]);
				end else begin
					px_q <= neg_q ? x1_q - SW'(k_q) - SW'(1) : x1_q + SW'(k_q) + SW'(1);
					py_q <= y1_q + SW'(acc_n[31:16]);
				end
			end
			alre_pkg::ST_LN_BL_WR: begin
				second_q <= ~second_q;
				if (second_q) k_q <= k_q + 16'd1;
			end
			default: ;
		endcase
	end

	// a held response keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable({rsp.pixel_red, rsp.pixel_green,
			rsp.pixel_blue, rsp.pixel_alpha, rsp.out_of_range})))
		else $error("held response changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !cmd.ready)
		else $error("request taken while response pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == alre_pkg::ST_LN_DIV) |-> (div_cnt_q <= 6'd32))
		else $error("divider count overrun");
endmodule

// ----- dv/alre_line_checker.sv -----
// checker for the raster engine: keeps a shadow frame store and compares every response
`timescale 1ns / 1ps
module alre_line_checker (
	input logic clk,
	input logic arst_n,
	alre_cmd_if.sink watch_cmd,
	alre_rsp_if.sink watch_rsp,
	alre_cfg_if.sink watch_cfg,
	output int fail_count,
	output int pending_count
);
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       oor;
	} pixel_resp_t;

	logic [31:0] shadow_store [0:4095];
	logic [6:0] width_reg;
	logic [6:0] height_reg;
	pixel_resp_t resp_queue [$];
	int mismatches;

	function automatic int cur_w();
		int w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > 64) w = 64;
		return w;
	endfunction

	function automatic int cur_h();
		int h;
		h = height_reg;
		if (h < 1) h = 1;
		if (h > 64) h = 64;
		return h;
	endfunction

	function automatic bit on_image(int x, int y);
		return x >= 0 && y >= 0 && x < cur_w() && y < cur_h();
	endfunction

	function automatic void set_px(int x, int y, logic [31:0] c);
		if (on_image(x, y)) shadow_store[y * 64 + x] = c;
	endfunction

	function automatic void mix_pixel(int x, int y, logic [31:0] c, int wt);
		logic [31:0] old;
		logic [31:0] res;
		int d;
		int s;
		if (!on_image(x, y)) return;
		old = shadow_store[y * 64 + x];
		for (int k = 0; k < 4; k++) begin
			d = (old >> (8 * k)) & 255;
			s = (c >> (8 * k)) & 255;
			res[8 * k +: 8] = 8'(((d * (256 - wt)) >> 8) + ((s * wt) >> 8));
		end
		shadow_store[y * 64 + x] = res;
	endfunction

	function automatic int clip(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void trace_line(int x1, int y1, int x2, int y2, logic [31:0] c);
		int t, dx, dy, xdir, pos, f;
		int unsigned acc, slope;
		if (y1 > y2) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
		end
		x1 = clip(x1, cur_w() - 1); x2 = clip(x2, cur_w() - 1);
		y1 = clip(y1, cur_h() - 1); y2 = clip(y2, cur_h() - 1);
		set_px(x1, y1, c);
		set_px(x2, y2, c);
		dx = x2 - x1;
		dy = y2 - y1;
		xdir = 1;
		if (dx < 0) begin
			xdir = -1;
			dx = -dx;
		end
		acc = 0;
		if (dx == 0) begin
			for (int k = 0; k < dy; k++) set_px(x1, y1 + k, c);
		end else if (dy == 0) begin
			t = x1 < x2 ? x1 : x2;
			for (int k = 0; k < dx; k++) set_px(t + k, y1, c);
		end else if (dx == dy) begin
			for (int k = 0; k < dy; k++) set_px(x1 + k * xdir, y1 + k, c);
		end else if (dy > dx) begin
			slope = (dx << 16) / dy;
			for (int k = 0; k < dy; k++) begin
				acc += slope;
				y1++;
				pos = x1 + xdir * int'(acc >> 16);
				f = (acc >> 8) & 255;
				mix_pixel(pos, y1, c, 255 - f);
				mix_pixel(pos + xdir, y1, c, f);
			end
		end else begin
			slope = (dy << 16) / dx;
			for (int k = 0; k < dx; k++) begin
				acc += slope;
				x1 += xdir;
				pos = y1 + int'(acc >> 16);
				f = (acc >> 8) & 255;
				mix_pixel(x1, pos, c, 255 - f);
				mix_pixel(x1, pos + 1, c, f);
			end
		end
	endfunction

	function automatic pixel_resp_t run_command(alre_pkg::kind_t kind, int xs, int ys,
			int xe, int ye, logic [31:0] c);
		pixel_resp_t r;
		logic [31:0] p;
		r = '0;
		case (kind)
			alre_pkg::KIND_READ: begin
				if (on_image(xs, ys)) begin
					p = shadow_store[ys * 64 + xs];
					r.red = p[7:0];
					r.green = p[15:8];
					r.blue = p[23:16];
					r.alpha = p[31:24];
				end else begin
					r.oor = 1'b1;
				end
			end
			alre_pkg::KIND_LINE: trace_line(xs, ys, xe, ye, c);
			alre_pkg::KIND_FILL: begin
				for (int y = 0; y < cur_h(); y++)
					for (int x = 0; x < cur_w(); x++) shadow_store[y * 64 + x] = c;
			end
			default: ;
		endcase
		return r;
	endfunction

	assign fail_count = mismatches;
	assign pending_count = resp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_resp_t want;
		pixel_resp_t got;
		if (!arst_n) begin
			for (int i = 0; i < 4096; i++) shadow_store[i] = '0;
			width_reg = 7'd64;
			height_reg = 7'd64;
			resp_queue.delete();
			mismatches = 0;
		end else begin
			if (watch_cfg.valid && watch_cfg.ready) begin
				if (watch_cfg.index == alre_pkg::REG_WIDTH) width_reg = watch_cfg.data;
				else height_reg = watch_cfg.data;
			end
			if (watch_rsp.valid && watch_rsp.ready) begin
				got = {watch_rsp.pixel_red, watch_rsp.pixel_green, watch_rsp.pixel_blue,
					watch_rsp.pixel_alpha, watch_rsp.out_of_range};
				if (resp_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected response %h", got);
				end else begin
					want = resp_queue.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("response mismatch: expected r%h g%h b%h a%h o%b,",
								want.red, want.green, want.blue, want.alpha, want.oor,
								" got r%h g%h b%h a%h o%b",
								got.red, got.green, got.blue, got.alpha, got.oor);
					end
				end
			end
			if (watch_cmd.valid && watch_cmd.ready)
				resp_queue.push_back(run_command(alre_pkg::kind_t'(watch_cmd.kind),
					int'($signed(watch_cmd.x_start)), int'($signed(watch_cmd.y_start)),
					int'($signed(watch_cmd.x_end)), int'($signed(watch_cmd.y_end)),
					{watch_cmd.alpha, watch_cmd.blue, watch_cmd.green, watch_cmd.red}));
		end
	end
endmodule

// ----- dv/antialiased_line_raster_engine_tb.sv -----
// testbench top: command stimulus, configuration phases and verdict for the raster engine
`timescale 1ns / 1ps
module antialiased_line_raster_engine_tb;
	localparam int STALL_LIMIT = 40000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_rsp;
	int quiet_cycles;

	alre_cmd_if cmd ();
	alre_rsp_if rsp ();
	alre_cfg_if cfg ();

	antialiased_line_raster_engine i_dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.cfg(cfg));

	alre_line_checker i_checker (.clk(clk), .arst_n(arst_n), .watch_cmd(cmd),
		.watch_rsp(rsp), .watch_cfg(cfg), .fail_count(fail_count),
		.pending_count(pending_count));

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("antialiased_line_raster_engine_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic send_request(alre_pkg::kind_t kind, logic [15:0] xs, logic [15:0] ys,
			logic [15:0] xe, logic [15:0] ye, logic [31:0] c);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		cmd.valid <= 1'b1;
		cmd.kind <= kind;
		cmd.x_start <= xs;
		cmd.y_start <= ys;
		cmd.x_end <= xe;
		cmd.y_end <= ye;
		{cmd.alpha, cmd.blue, cmd.green, cmd.red} <= c;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		cmd.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(alre_pkg::reg_idx_t idx, logic [6:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mostly small coordinates near the image, now and then a wild one
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'(-$urandom_range(8));
			2: return 16'($urandom_range(127));
			default: return 16'($urandom_range(63));
		endcase
	endfunction

	task automatic random_request();
		int r;
		alre_pkg::kind_t kind;
		r = $urandom_range(99);
		if (r < 45) kind = alre_pkg::KIND_READ;
		else if (r < 90) kind = alre_pkg::KIND_LINE;
		else if (r < 96) kind = alre_pkg::KIND_FILL;
		else kind = alre_pkg::KIND_NONE;
		send_request(kind, pick_coord(), pick_coord(), pick_coord(), pick_coord(), $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		hold_rsp = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cmd.valid = 1'b0;
		cmd.kind = alre_pkg::KIND_READ;
		cmd.x_start = '0;
		cmd.y_start = '0;
		cmd.x_end = '0;
		cmd.y_end = '0;
		cmd.red = '0;
		cmd.green = '0;
		cmd.blue = '0;
		cmd.alpha = '0;
		cfg.valid = 1'b0;
		cfg.index = alre_pkg::REG_WIDTH;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each command kind, plain and blended lines
		send_request(alre_pkg::KIND_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
		send_request(alre_pkg::KIND_READ, 16'h8000, 16'h7fff, 16'hffff, 16'hffff,
			32'hffffffff);
		send_request(alre_pkg::KIND_READ, 16'd64, 16'd63, 16'd0, 16'd0, 32'h0);
		send_request(alre_pkg::KIND_FILL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h11223344);
		send_request(alre_pkg::KIND_LINE, 16'd5, 16'd2, 16'd5, 16'd40, 32'hffffffff);
		send_request(alre_pkg::KIND_LINE, 16'd50, 16'd7, 16'd3, 16'd7, 32'h00ff00ff);
		send_request(alre_pkg::KIND_LINE, 16'd10, 16'd10, 16'd30, 16'd30, 32'hff0000ff);
		send_request(alre_pkg::KIND_LINE, 16'd40, 16'd60, 16'd20, 16'd5, 32'h80808080);
		send_request(alre_pkg::KIND_LINE, 16'd0, 16'd0, 16'd63, 16'd20, 32'h12345678);
		send_request(alre_pkg::KIND_LINE, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
			32'habcdef01);
		send_request(alre_pkg::KIND_LINE, 16'd63, 16'd0, 16'd0, 16'd63, 32'hffffffff);
		send_request(alre_pkg::KIND_LINE, 16'd9, 16'd9, 16'd9, 16'd9, 32'h5a5a5a5a);
		send_request(alre_pkg::KIND_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			32'hffffffff);
		for (int i = 0; i < 6; i++)
			send_request(alre_pkg::KIND_READ, 16'($urandom_range(63)),
				16'($urandom_range(63)), 16'd0, 16'd0, 32'h0);
		send_request(alre_pkg::KIND_READ, 16'd9, 16'd9, 16'd0, 16'd0, 32'h0);
		send_request(alre_pkg::KIND_READ, 16'd63, 16'd63, 16'd0, 16'd0, 32'h0);
		drain();

		// random phases over several image sizes and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				1: begin
					write_reg(alre_pkg::REG_WIDTH, 7'd1);
					write_reg(alre_pkg::REG_HEIGHT, 7'd1);
				end
				2: begin
					write_reg(alre_pkg::REG_WIDTH, 7'd0);
					write_reg(alre_pkg::REG_HEIGHT, 7'd127);
				end
				3: begin
					write_reg(alre_pkg::REG_WIDTH, 7'd17);
					write_reg(alre_pkg::REG_HEIGHT, 7'd40);
				end
				5: begin
					write_reg(alre_pkg::REG_WIDTH, 7'd64);
					write_reg(alre_pkg::REG_HEIGHT, 7'd9);
				end
				6: begin
					write_reg(alre_pkg::REG_WIDTH, 7'd100);
					write_reg(alre_pkg::REG_HEIGHT, 7'd64);
				end
				default: ;
			endcase
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 74 : 23) : 0;
			recv_idle_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 74 : 23) : 0;
			if (ph == 4) begin
				fork
					begin
						hold_rsp = 1'b1;
						repeat (3000) @(posedge clk);
						hold_rsp = 1'b0;
					end
					for (int i = 0; i < 10; i++) random_request();
				join
			end
			for (int i = 0; i < 102; i++) random_request();
			drain();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("antialiased_line_raster_engine_tb: done, clean");
		else
			$display("antialiased_line_raster_engine_tb: done, errors");
		$finish;
	end
endmodule
